// ===== hw/rtl/ttw_pkg.sv =====
// Shared constants, types and helpers for the text terminal writer.
package ttw_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int COPY_COUNT    = CELL_COUNT - SCREEN_WIDTH;
    localparam int ADDR_W        = $clog2(CELL_COUNT);

    // Port widths are fixed by the interface.
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int IDX_W  = 11;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int LOC_W  = 11;
    localparam int CELL_W = 16;
    localparam int LOCF_W = ROW_W + COL_W;

    localparam int TAB_STOP    = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

    // Commands as classified by the front end.
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_PRINT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_BS    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TAB   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CR    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LF    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_NOP   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd6;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] addr;
    } ttw_item_t;

    // Linear cell location of a cursor position.
    function automatic logic [LOCF_W-1:0] loc_of(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
        return LOCF_W'(row) * LOCF_W'(SCREEN_WIDTH) + LOCF_W'(col);
    endfunction

endpackage

// ===== hw/rtl/ttw_front.sv =====
// Front end: accepts words on the input channel and classifies them into commands.
module ttw_front (
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ttw_pkg::OP_W-1:0]      operation,
    input  logic [ttw_pkg::CHAR_W-1:0]    character,
    input  logic [ttw_pkg::IDX_W-1:0]     cell_index,
    input  logic                          accept_en,
    input  logic                          q_full,
    output logic                          q_push,
    output ttw_pkg::ttw_item_t            q_item
);
    import ttw_pkg::*;

    logic in_range;

    assign in_ready = accept_en && !q_full;
    assign q_push   = in_valid && in_ready;
    assign in_range = (LOCF_W + 1)'(cell_index) < (LOCF_W + 1)'(CELL_COUNT);

    always_comb
    begin
        q_item.ch   = character;
        q_item.addr = ADDR_W'(cell_index);
        priority if (operation == OP_CLEAR)
        begin
            q_item.cmd = CMD_CLEAR;
        end
        else if (operation == OP_READ)
        begin
            // A read beyond the screen returns zero, like an idle operation.
            q_item.cmd = in_range ? CMD_READ : CMD_NOP;
        end
        else if (operation != OP_PUT)
        begin
            q_item.cmd = CMD_NOP;
        end
        else if (character == CH_BS)
        begin
            q_item.cmd = CMD_BS;
        end
        else if (character == CH_TAB)
        begin
            q_item.cmd = CMD_TAB;
        end
        else if (character == CH_CR)
        begin
            q_item.cmd = CMD_CR;
        end
        else if (character == CH_LF)
        begin
            q_item.cmd = CMD_LF;
        end
        else if (character >= BLANK_CHAR)
        begin
            q_item.cmd = CMD_PRINT;
        end
        else
        begin
            q_item.cmd = CMD_NOP;
        end
    end

endmodule

// ===== hw/rtl/ttw_queue.sv =====
// Short command queue between the front end and the back end.
module ttw_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ttw_pkg::ttw_item_t push_item,
    output logic               full,
    input  logic               pop,
    output ttw_pkg::ttw_item_t head,
    output logic               empty
);
    import ttw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ttw_item_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/ttw_back.sv =====
// Back end: screen memory, cursor, scroll and clear sequencer, and result register.
module ttw_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ttw_pkg::ATTR_W-1:0]    color_attr,
    input  logic                          q_empty,
    input  ttw_pkg::ttw_item_t            q_head,
    output logic                          q_pop,
    output logic                          init_done,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ttw_pkg::ROW_W-1:0]     cursor_row,
    output logic [ttw_pkg::COL_W-1:0]     cursor_column,
    output logic [ttw_pkg::LOC_W-1:0]     cursor_location,
    output logic [ttw_pkg::CELL_W-1:0]    cell_value,
    output logic                          scrolled
);
    import ttw_pkg::*;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EMIT  = 3'd2;
    localparam logic [2:0] S_COPY  = 3'd3;
    localparam logic [2:0] S_BLANK = 3'd4;
    localparam logic [2:0] S_CLEAR = 3'd5;

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(COPY_COUNT);

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [ADDR_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0]  cnt_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic               copy_vld_reg;
    logic               copy_vld_next;
    logic [ADDR_W-1:0]  copy_addr_reg;
    logic [ADDR_W-1:0]  copy_addr_next;
    logic               pend_read_reg;
    logic               pend_read_next;
    logic               pend_scroll_reg;
    logic               pend_scroll_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_load;

    logic [CELL_W-1:0]  mem [CELL_COUNT];
    logic [CELL_W-1:0]  rd_data_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;

    logic [ROW_W-1:0]   cur_row_reg;
    logic [COL_W-1:0]   cur_col_reg;
    logic [LOC_W-1:0]   cur_loc_reg;
    logic [CELL_W-1:0]  cell_value_reg;
    logic               scrolled_reg;

    logic [COL_W:0]     col_ext;
    logic [ROW_W:0]     row_ext;
    logic [COL_W:0]     col_mv;
    logic [ROW_W:0]     row_mv;
    logic [COL_W:0]     col_wr;
    logic [ROW_W:0]     row_wr;
    logic               put_scroll;
    logic [ROW_W-1:0]   put_row;
    logic [COL_W-1:0]   put_col;
    logic [LOCF_W-1:0]  cur_loc_full;
    logic [CELL_W-1:0]  blank_cell;

    assign blank_cell   = {color_attr, BLANK_CHAR};
    assign cur_loc_full = loc_of(row_reg, col_reg);
    assign init_done    = state_reg != S_INIT;

    // Cursor movement for a put command.
    always_comb
    begin
        col_ext = {1'b0, col_reg};
        row_ext = {1'b0, row_reg};
        col_mv  = col_ext;
        row_mv  = row_ext;
        unique case (q_head.cmd)
            CMD_PRINT:
            begin
                col_mv = col_ext + 1'b1;
            end
            CMD_BS:
            begin
                col_mv = (col_reg != '0) ? col_ext - 1'b1 : col_ext;
            end
            CMD_TAB:
            begin
                col_mv = (col_ext + (COL_W + 1)'(TAB_STOP)) & ~(COL_W + 1)'(TAB_STOP - 1);
            end
            CMD_CR:
            begin
                col_mv = '0;
            end
            CMD_LF:
            begin
                col_mv = '0;
                row_mv = row_ext + 1'b1;
            end
            CMD_NOP, CMD_CLEAR, CMD_READ:
            begin
                col_mv = col_ext;
            end
        endcase
        col_wr = col_mv;
        row_wr = row_mv;
        if (col_mv >= (COL_W + 1)'(SCREEN_WIDTH))
        begin
            col_wr = '0;
            row_wr = row_mv + 1'b1;
        end
        put_scroll = row_wr >= (ROW_W + 1)'(SCREEN_HEIGHT);
        put_row    = put_scroll ? ROW_W'(SCREEN_HEIGHT - 1) : row_wr[ROW_W-1:0];
        put_col    = col_wr[COL_W-1:0];
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        copy_vld_next    = 1'b0;
        copy_addr_next   = copy_addr_reg;
        pend_read_next   = pend_read_reg;
        pend_scroll_next = pend_scroll_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_load         = 1'b0;
        q_pop            = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = cnt_reg;
        mem_wdata        = blank_cell;
        mem_re           = 1'b0;
        mem_raddr        = q_head.addr;
        unique case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = {RESET_ATTR, BLANK_CHAR};
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop            = 1'b1;
                    pend_read_next   = 1'b0;
                    pend_scroll_next = 1'b0;
                    state_next       = S_EMIT;
                    unique case (q_head.cmd)
                        CMD_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            cnt_next   = '0;
                            state_next = S_CLEAR;
                        end
                        CMD_READ:
                        begin
                            mem_re         = 1'b1;
                            pend_read_next = 1'b1;
                        end
                        CMD_NOP:
                        begin
                            pend_read_next = 1'b0;
                        end
                        CMD_PRINT, CMD_BS, CMD_TAB, CMD_CR, CMD_LF:
                        begin
                            mem_we    = q_head.cmd == CMD_PRINT;
                            mem_waddr = cur_loc_full[ADDR_W-1:0];
                            mem_wdata = {color_attr, q_head.ch};
                            row_next  = put_row;
                            col_next  = put_col;
                            if (put_scroll)
                            begin
                                pend_scroll_next = 1'b1;
                                cnt_next         = '0;
                                state_next       = S_COPY;
                            end
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_COPY:
            begin
                // Reads run one cell ahead of the writes that move each cell up a row.
                mem_we    = copy_vld_reg;
                mem_waddr = copy_addr_reg;
                mem_wdata = rd_data_reg;
                if (cnt_reg == COPY_END)
                begin
                    state_next = S_BLANK;
                end
                else
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = ADDR_W'((ADDR_W + 1)'(cnt_reg) + (ADDR_W + 1)'(SCREEN_WIDTH));
                    copy_vld_next  = 1'b1;
                    copy_addr_next = cnt_reg;
                    cnt_next       = cnt_reg + 1'b1;
                end
            end
            S_BLANK, S_CLEAR:
            begin
                mem_we = 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            cnt_reg         <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            copy_vld_reg    <= 1'b0;
            copy_addr_reg   <= '0;
            pend_read_reg   <= 1'b0;
            pend_scroll_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            copy_vld_reg    <= copy_vld_next;
            copy_addr_reg   <= copy_addr_next;
            pend_read_reg   <= pend_read_next;
            pend_scroll_reg <= pend_scroll_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            cur_row_reg    <= row_reg;
            cur_col_reg    <= col_reg;
            cur_loc_reg    <= cur_loc_full[LOC_W-1:0];
            cell_value_reg <= pend_read_reg ? rd_data_reg : '0;
            scrolled_reg   <= pend_scroll_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign cursor_row      = cur_row_reg;
    assign cursor_column   = cur_col_reg;
    assign cursor_location = cur_loc_reg;
    assign cell_value      = cell_value_reg;
    assign scrolled        = scrolled_reg;

    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg < ROW_W'(SCREEN_HEIGHT)) && ((COL_W + 1)'(col_reg) < (COL_W + 1)'(SCREEN_WIDTH)))
        else $error("cursor left the screen");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((ADDR_W + 1)'(mem_waddr) < (ADDR_W + 1)'(CELL_COUNT)))
        else $error("screen write beyond the last cell");

    a_copy_only_in_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        copy_vld_reg |-> (state_reg == S_COPY))
        else $error("pending row copy outside the scroll copy phase");

    a_scroll_on_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && pend_scroll_reg) |-> (row_reg == ROW_W'(SCREEN_HEIGHT - 1)))
        else $error("scrolled result without the cursor on the last row");

    a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY || state_reg == S_BLANK || state_reg == S_CLEAR) |=> !q_pop
        || state_reg != S_IDLE)
        else $error("command taken while the screen sweep runs");

endmodule

// ===== hw/rtl/text_terminal_writer_core.sv =====
// Top level of the text terminal writer: configuration register and block wiring.
//
//  Channel  Handshake                Payload
//  input    in_valid / in_ready      operation, character, cell_index
//  output   out_valid / out_ready    cursor_row, cursor_column, cursor_location,
//                                    cell_value, scrolled
//  config   cfg_valid / cfg_ready    cfg_data (color attribute)
//
// A put, read or idle word goes through dispatch in the back end, then the result register.
// Clear blanks every cell, and a scrolling put moves each row up one and blanks the bottom row;
// both go cell by cell through the single write port of the screen memory.
// After reset a pass over all SCREEN_WIDTH * SCREEN_HEIGHT cells (2000) blanks the screen;
// in_ready stays low meanwhile, while configuration writes are taken at any time.
// A two-word queue lets the input side keep taking words while the back end is busy, until it fills.
module text_terminal_writer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ttw_pkg::OP_W-1:0]      operation,
    input  logic [ttw_pkg::CHAR_W-1:0]    character,
    input  logic [ttw_pkg::IDX_W-1:0]     cell_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ttw_pkg::ROW_W-1:0]     cursor_row,
    output logic [ttw_pkg::COL_W-1:0]     cursor_column,
    output logic [ttw_pkg::LOC_W-1:0]     cursor_location,
    output logic [ttw_pkg::CELL_W-1:0]    cell_value,
    output logic                          scrolled,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ttw_pkg::ATTR_W-1:0]    cfg_data
);
    import ttw_pkg::*;

    logic [ATTR_W-1:0] color_attr_reg;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    ttw_item_t         q_item;
    ttw_item_t         q_head;
    logic              init_done;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_attr_reg <= RESET_ATTR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            color_attr_reg <= cfg_data;
        end
    end

    ttw_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .character  (character),
        .cell_index (cell_index),
        .accept_en  (init_done),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_item)
    );

    ttw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    ttw_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .color_attr      (color_attr_reg),
        .q_empty         (q_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .init_done       (init_done),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .cursor_row      (cursor_row),
        .cursor_column   (cursor_column),
        .cursor_location (cursor_location),
        .cell_value      (cell_value),
        .scrolled        (scrolled)
    );

endmodule
